// File: rtl/core/cms_pkg.sv
package cms_pkg;

  // Mission limits
  localparam int unsigned MAX_ROWS         = 1023;
  localparam int unsigned POS_WIDTH        = 24;
  localparam int unsigned MIN_HOLD_TICKS   = 8;
  localparam int unsigned PHASE_HOLD_TICKS = 25;

  // Field and state widths
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned HOLD_W     = 24;
  localparam int unsigned NE_W       = POS_WIDTH + 1;
  localparam int unsigned DOWN_W     = 18;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Mission phases
  localparam logic [2:0] PH_WARMUP  = 3'd0;
  localparam logic [2:0] PH_TAKEOFF = 3'd1;
  localparam logic [2:0] PH_CRUISE  = 3'd2;
  localparam logic [2:0] PH_RETURN  = 3'd3;
  localparam logic [2:0] PH_LAND    = 3'd4;
  localparam logic [2:0] PH_LANDED  = 3'd5;

  // Vehicle commands
  localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MODE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ARM    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LAND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISARM = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SPACING   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_X        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_Y        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP_TICKS  = 3'd7;

  // Output item sources
  localparam logic [1:0] OSEL_HOME_CH   = 2'd0;
  localparam logic [1:0] OSEL_HOME_LAND = 2'd1;
  localparam logic [1:0] OSEL_WAYPT     = 2'd2;
  localparam logic [1:0] OSEL_CMD       = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic             box_upd;
    logic             warm_inc;
    logic             out_load;
    logic [1:0]       osel;
    logic [CMD_W-1:0] out_cmd;
    logic             out_last;
    logic             cruise_init;
    logic             rows_start;
    logic             rows_load;
    logic             land_init;
    logic             land_step;
    logic             wp_wrap;
    logic             wp_mul;
    logic             wp_calc;
    logic             wp_save;
    logic             hold_dec;
    logic             idx_adv;
    logic             diff;
    logic             square;
    logic             sqrt_start;
    logic             div_hold_start;
    logic             hold_load;
  } cms_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic warm_active;
    logic warm_last;
    logic warm_zero;
    logic rows_zero;
    logic hold_zero;
    logic land_low;
    logic out_free;
    logic sqrt_busy;
    logic div_busy;
  } cms_sts_t;

endpackage

// File: rtl/core/cms_ifs.sv
interface cms_in_if;
  import cms_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic signed [POS_WIDTH-1:0] vertex_x;
  logic signed [POS_WIDTH-1:0] vertex_y;
  modport source (output valid, cmd, vertex_x, vertex_y, input ready);
  modport sink   (input valid, cmd, vertex_x, vertex_y, output ready);
endinterface

interface cms_out_if;
  import cms_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     setpoint_valid;
  logic signed [NE_W-1:0]   north;
  logic signed [NE_W-1:0]   east;
  logic signed [DOWN_W-1:0] down;
  logic [CMD_W-1:0]         command;
  logic                     last;
  modport source (output valid, setpoint_valid, north, east, down, command, last,
                  input ready);
  modport sink   (input valid, setpoint_valid, north, east, down, command, last,
                  output ready);
endinterface

interface cms_cfg_if;
  import cms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/coverage_mission_sequencer_unit.sv
// Vertex item: taken without leaving idle, no result.
// Tick item: 0 to 3 result items.
// Cruise tick that reloads the hold: input busy after acceptance until the 31-step square
// root and the 32-step divider are done; end of takeoff hold also waits for the row count
// on the divider. Stalls on the result side also keep the input busy.
// Reset (rst_ni low, asynchronous): registers to defaults, mission in warmup,
// counters and flags cleared, no result pending.
module coverage_mission_sequencer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  cms_in_if.sink    in_i,
  cms_out_if.source out_o,
  cms_cfg_if.sink   cfg_i
);
  import cms_pkg::*;

  cms_ctl_t ctl;
  cms_sts_t sts;

  cms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  cms_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vertex_x_i (in_i.vertex_x),
    .vertex_y_i (in_i.vertex_y),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .cfg_i      (cfg_i),
    .out_o      (out_o)
  );

endmodule

// File: rtl/core/cms_ctrl.sv
module cms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_cmd_i,
  output logic              in_ready_o,
  input  cms_pkg::cms_sts_t sts_i,
  output cms_pkg::cms_ctl_t ctl_o
);
  import cms_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_W_HOME    = 5'd1;
  localparam logic [4:0] S_W_MODE    = 5'd2;
  localparam logic [4:0] S_W_ARM     = 5'd3;
  localparam logic [4:0] S_HOLD      = 5'd4;
  localparam logic [4:0] S_ROWS_W    = 5'd5;
  localparam logic [4:0] S_CR_MUL    = 5'd6;
  localparam logic [4:0] S_CR_CALC   = 5'd7;
  localparam logic [4:0] S_CR_EMIT   = 5'd8;
  localparam logic [4:0] S_NX_MUL    = 5'd9;
  localparam logic [4:0] S_NX_CALC   = 5'd10;
  localparam logic [4:0] S_DIFF      = 5'd11;
  localparam logic [4:0] S_SQ        = 5'd12;
  localparam logic [4:0] S_SQRT_GO   = 5'd13;
  localparam logic [4:0] S_SQRT_W    = 5'd14;
  localparam logic [4:0] S_DIV_W     = 5'd15;
  localparam logic [4:0] S_LAND      = 5'd16;
  localparam logic [4:0] S_LAND_EMIT = 5'd17;
  localparam logic [4:0] S_LAND_CMD  = 5'd18;
  localparam logic [4:0] S_DISARM    = 5'd19;

  logic [4:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic [4:0] pticks_q, pticks_d;
  logic       lsent_q, lsent_d;
  logic       dsent_q, dsent_d;
  cms_ctl_t   c;

  assign in_ready_o = (state_q == S_IDLE);
  assign ctl_o      = c;

  // Sequence one item at a time
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    pticks_d = pticks_q;
    lsent_d  = lsent_q;
    dsent_d  = dsent_q;
    c        = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_cmd_i) begin
            c.box_upd = (phase_q == PH_WARMUP) && sts_i.warm_zero;
          end else if (sts_i.warm_active) begin
            state_d = S_W_HOME;
          end else begin
            unique case (phase_q)
              PH_WARMUP: phase_d = PH_TAKEOFF;
              PH_TAKEOFF, PH_RETURN: state_d = S_HOLD;
              PH_CRUISE: begin
                if (sts_i.rows_zero) begin
                  phase_d = PH_RETURN;
                end else begin
                  c.wp_wrap = 1'b1;
                  state_d   = S_CR_MUL;
                end
              end
              PH_LAND: state_d = S_LAND;
              default: if (!dsent_q) state_d = S_DISARM;
            endcase
          end
        end
      end
      S_W_HOME: begin
        if (sts_i.out_free) begin
          c.out_load = 1'b1;
          c.osel     = OSEL_HOME_CH;
          c.out_last = !sts_i.warm_last;
          c.warm_inc = 1'b1;
          state_d    = sts_i.warm_last ? S_W_MODE : S_IDLE;
        end
      end
      S_W_MODE: begin
        if (sts_i.out_free) begin
          c.out_load = 1'b1;
          c.osel     = OSEL_CMD;
          c.out_cmd  = CMD_MODE;
          state_d    = S_W_ARM;
        end
      end
      S_W_ARM: begin
        if (sts_i.out_free) begin
          c.out_load = 1'b1;
          c.osel     = OSEL_CMD;
          c.out_cmd  = CMD_ARM;
          c.out_last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_HOLD: begin
        if (sts_i.out_free) begin
          c.out_load = 1'b1;
          c.osel     = OSEL_HOME_CH;
          c.out_last = 1'b1;
          state_d    = S_IDLE;
          if (pticks_q >= 5'(PHASE_HOLD_TICKS - 1)) begin
            pticks_d = '0;
            if (phase_q == PH_TAKEOFF) begin
              phase_d       = PH_CRUISE;
              c.cruise_init = 1'b1;
              c.rows_start  = 1'b1;
              state_d       = S_ROWS_W;
            end else begin
              phase_d     = PH_LAND;
              c.land_init = 1'b1;
            end
          end else begin
            pticks_d = pticks_q + 5'd1;
          end
        end
      end
      S_ROWS_W: begin
        if (!sts_i.div_busy) begin
          c.rows_load = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_CR_MUL: begin
        c.wp_mul = 1'b1;
        state_d  = S_CR_CALC;
      end
      S_CR_CALC: begin
        c.wp_calc = 1'b1;
        state_d   = S_CR_EMIT;
      end
      S_CR_EMIT: begin
        if (sts_i.out_free) begin
          c.out_load = 1'b1;
          c.osel     = OSEL_WAYPT;
          c.out_last = 1'b1;
          c.wp_save  = 1'b1;
          if (!sts_i.hold_zero) begin
            c.hold_dec = 1'b1;
            state_d    = S_IDLE;
          end else begin
            c.idx_adv = 1'b1;
            state_d   = S_NX_MUL;
          end
        end
      end
      S_NX_MUL: begin
        c.wp_mul = 1'b1;
        state_d  = S_NX_CALC;
      end
      S_NX_CALC: begin
        c.wp_calc = 1'b1;
        state_d   = S_DIFF;
      end
      S_DIFF: begin
        c.diff  = 1'b1;
        state_d = S_SQ;
      end
      S_SQ: begin
        c.square = 1'b1;
        state_d  = S_SQRT_GO;
      end
      S_SQRT_GO: begin
        c.sqrt_start = 1'b1;
        state_d      = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (!sts_i.sqrt_busy) begin
          c.div_hold_start = 1'b1;
          state_d          = S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (!sts_i.div_busy) begin
          c.hold_load = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_LAND: begin
        c.land_step = 1'b1;
        state_d     = S_LAND_EMIT;
      end
      S_LAND_EMIT: begin
        if (sts_i.out_free) begin
          c.out_load = 1'b1;
          c.osel     = OSEL_HOME_LAND;
          c.out_last = lsent_q;
          if (sts_i.land_low) phase_d = PH_LANDED;
          state_d = lsent_q ? S_IDLE : S_LAND_CMD;
        end
      end
      S_LAND_CMD: begin
        if (sts_i.out_free) begin
          c.out_load = 1'b1;
          c.osel     = OSEL_CMD;
          c.out_cmd  = CMD_LAND;
          c.out_last = 1'b1;
          lsent_d    = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DISARM: begin
        if (sts_i.out_free) begin
          c.out_load = 1'b1;
          c.osel     = OSEL_CMD;
          c.out_cmd  = CMD_DISARM;
          c.out_last = 1'b1;
          dsent_d    = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_WARMUP;
      pticks_q <= '0;
      lsent_q  <= 1'b0;
      dsent_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      pticks_q <= pticks_d;
      lsent_q  <= lsent_d;
      dsent_q  <= dsent_d;
    end
  end

endmodule

// File: rtl/core/cms_dp.sv
module cms_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [cms_pkg::POS_WIDTH-1:0] vertex_x_i,
  input  logic signed [cms_pkg::POS_WIDTH-1:0] vertex_y_i,
  input  cms_pkg::cms_ctl_t                    ctl_i,
  output cms_pkg::cms_sts_t                    sts_o,
  cms_cfg_if.sink                              cfg_i,
  cms_out_if.source                            out_o
);
  import cms_pkg::*;

  localparam logic signed [NE_W:0] NE_MAX = (NE_W+1)'((1 << POS_WIDTH) - 1);
  localparam logic signed [NE_W:0] NE_MIN = -(NE_W+1)'(1 << POS_WIDTH);

  // Configuration registers
  logic [16:0]                 rs_q, ch_q;
  logic signed [POS_WIDTH-1:0] ox_q, oy_q, hx_q, hy_q;
  logic [13:0]                 spd_q;
  logic [7:0]                  wt_q;

  // Mission state
  logic signed [POS_WIDTH-1:0] bx_lo_q, bx_hi_q, by_lo_q, by_hi_q;
  logic                        any_q;
  logic [7:0]                  warm_q;
  logic [ROW_W-1:0]            rows_q;
  logic [IDX_W-1:0]            idx_q;
  logic [HOLD_W-1:0]           hold_q;
  logic [16:0]                 land_q;

  // Waypoint and hold arithmetic
  logic [26:0]                 prod_q;
  logic signed [NE_W-1:0]      gx_q, gy_q, cx_q, cy_q;
  logic [25:0]                 ax_q, ay_q;
  logic [51:0]                 ax2_q, ay2_q;
  logic [61:0]                 sx_q, sres_q, sbit_q;
  logic                        sbusy_q;
  logic [31:0]                 dq_q;
  logic [16:0]                 drem_q, dden_q;
  logic [4:0]                  dcnt_q;
  logic                        dbusy_q;

  // Output register
  logic                        ov_q, osv_q, olast_q;
  logic signed [NE_W-1:0]      on_q, oe_q;
  logic signed [DOWN_W-1:0]    od_q;
  logic [CMD_W-1:0]            ocmd_q;

  logic [11:0]                 npts, nxt;
  logic signed [28:0]          y_full;
  logic signed [POS_WIDTH-1:0] y_clamp, x_pick;
  logic signed [NE_W:0]        nd, ed, dx, dy;
  logic signed [NE_W-1:0]      n_sat, e_sat;
  logic [52:0]                 sq_sum;
  logic [61:0]                 sq_trial;
  logic signed [NE_W-1:0]      bw, bh;
  logic                        degen;
  logic [17:0]                 dtrial;
  logic [13:0]                 spd_f;
  logic signed [17:0]          land_t;
  logic                        out_free;

  assign cfg_i.ready = 1'b1;
  assign out_free    = !ov_q || out_o.ready;

  assign npts = {1'b0, rows_q, 1'b0} + 12'd2;
  assign nxt  = {1'b0, idx_q} + 12'd1;

  // Row ordinate, clamped to the box top, and the row end column
  assign y_full  = 29'(by_lo_q) + $signed({2'b00, prod_q});
  assign y_clamp = (y_full > 29'(by_hi_q)) ? by_hi_q : y_full[POS_WIDTH-1:0];
  assign x_pick  = (idx_q[0] ^ idx_q[1]) ? bx_hi_q : bx_lo_q;

  // Offsets from home, saturated
  assign nd    = (NE_W+1)'(gy_q) - (NE_W+1)'(hy_q);
  assign ed    = (NE_W+1)'(gx_q) - (NE_W+1)'(hx_q);
  assign n_sat = (nd > NE_MAX) ? NE_MAX[NE_W-1:0] : (nd < NE_MIN) ? NE_MIN[NE_W-1:0]
                                                                   : nd[NE_W-1:0];
  assign e_sat = (ed > NE_MAX) ? NE_MAX[NE_W-1:0] : (ed < NE_MIN) ? NE_MIN[NE_W-1:0]
                                                                   : ed[NE_W-1:0];

  assign dx = (NE_W+1)'(gx_q) - (NE_W+1)'(cx_q);
  assign dy = (NE_W+1)'(gy_q) - (NE_W+1)'(cy_q);

  assign sq_sum   = {1'b0, ax2_q} + {1'b0, ay2_q};
  assign sq_trial = sres_q + sbit_q;

  assign bw    = NE_W'(bx_hi_q) - NE_W'(bx_lo_q);
  assign bh    = NE_W'(by_hi_q) - NE_W'(by_lo_q);
  assign degen = !any_q || (bw <= 0) || (bh <= 0);

  assign dtrial = {drem_q, dq_q[31]};
  assign spd_f  = (spd_q < 14'd10) ? 14'd10 : spd_q;
  assign land_t = $signed({1'b0, land_q}) - 18'sd10;

  assign sts_o.warm_active = (warm_q < wt_q);
  assign sts_o.warm_last   = ({1'b0, warm_q} + 9'd1) == {1'b0, wt_q};
  assign sts_o.warm_zero   = (warm_q == 8'd0);
  assign sts_o.rows_zero   = (rows_q == '0);
  assign sts_o.hold_zero   = (hold_q == '0);
  assign sts_o.land_low    = (land_q <= 17'd25);
  assign sts_o.out_free    = out_free;
  assign sts_o.sqrt_busy   = sbusy_q;
  assign sts_o.div_busy    = dbusy_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q  <= 17'd300;
      ch_q  <= 17'd1000;
      ox_q  <= 24'sd4000;
      oy_q  <= -24'sd3500;
      hx_q  <= 24'sd4000;
      hy_q  <= -24'sd4000;
      spd_q <= 14'd200;
      wt_q  <= 8'd12;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ROW_SPACING:   rs_q  <= cfg_i.data[16:0];
        REG_CRUISE_HEIGHT: ch_q  <= cfg_i.data[16:0];
        REG_ORIGIN_X:      ox_q  <= cfg_i.data;
        REG_ORIGIN_Y:      oy_q  <= cfg_i.data;
        REG_HOME_X:        hx_q  <= cfg_i.data;
        REG_HOME_Y:        hy_q  <= cfg_i.data;
        REG_CRUISE_SPEED:  spd_q <= cfg_i.data[13:0];
        REG_WARMUP_TICKS:  wt_q  <= cfg_i.data[7:0];
        default:           rs_q  <= rs_q;
      endcase
    end
  end

  // Bounding box
  always_ff @(posedge clk_i) begin
    if (ctl_i.box_upd) begin
      if (!any_q || vertex_x_i < bx_lo_q) bx_lo_q <= vertex_x_i;
      if (!any_q || vertex_x_i > bx_hi_q) bx_hi_q <= vertex_x_i;
      if (!any_q || vertex_y_i < by_lo_q) by_lo_q <= vertex_y_i;
      if (!any_q || vertex_y_i > by_hi_q) by_hi_q <= vertex_y_i;
    end
  end

  // Mission counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q  <= 1'b0;
      warm_q <= '0;
      rows_q <= '0;
      idx_q  <= '0;
      hold_q <= '0;
      land_q <= 17'd1000;
    end else begin
      if (ctl_i.box_upd) any_q <= 1'b1;
      if (ctl_i.warm_inc) warm_q <= warm_q + 8'd1;
      if (ctl_i.cruise_init) begin
        idx_q  <= '0;
        hold_q <= '0;
      end
      if (ctl_i.rows_load) begin
        if (degen) rows_q <= '0;
        else if (dq_q > 32'(MAX_ROWS)) rows_q <= ROW_W'(MAX_ROWS);
        else if (dq_q == 32'd0) rows_q <= ROW_W'(1);
        else rows_q <= dq_q[ROW_W-1:0];
      end
      if (ctl_i.wp_wrap && ({1'b0, idx_q} >= npts)) idx_q <= '0;
      if (ctl_i.idx_adv) idx_q <= (nxt >= npts) ? '0 : nxt[IDX_W-1:0];
      if (ctl_i.hold_dec) hold_q <= hold_q - HOLD_W'(1);
      if (ctl_i.hold_load) begin
        if (dq_q < 32'(MIN_HOLD_TICKS)) hold_q <= HOLD_W'(MIN_HOLD_TICKS);
        else if (dq_q[31:HOLD_W] != '0) hold_q <= '1;
        else hold_q <= dq_q[HOLD_W-1:0];
      end
      if (ctl_i.land_init) land_q <= ch_q;
      if (ctl_i.land_step) land_q <= (land_t < 18'sd20) ? 17'd20 : land_t[16:0];
    end
  end

  // Waypoint build and distance squares
  always_ff @(posedge clk_i) begin
    if (ctl_i.wp_mul) prod_q <= 27'(idx_q[IDX_W-1:1]) * 27'(rs_q);
    if (ctl_i.wp_calc) begin
      gx_q <= NE_W'(ox_q) + NE_W'(x_pick);
      gy_q <= NE_W'(oy_q) - NE_W'(y_clamp);
    end
    if (ctl_i.wp_save) begin
      cx_q <= gx_q;
      cy_q <= gy_q;
    end
    if (ctl_i.diff) begin
      ax_q <= dx[NE_W] ? 26'(-dx) : 26'(dx);
      ay_q <= dy[NE_W] ? 26'(-dy) : 26'(dy);
    end
    if (ctl_i.square) begin
      ax2_q <= 52'(ax_q) * 52'(ax_q);
      ay2_q <= 52'(ay_q) * 52'(ay_q);
    end
  end

  // Square root, two bits of radicand a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
    end else if (ctl_i.sqrt_start) begin
      sbusy_q <= 1'b1;
    end else if (sbusy_q && sbit_q[0]) begin
      sbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sqrt_start) begin
      sx_q   <= (62'(sq_sum) << 8) + (62'(sq_sum) << 7) + (62'(sq_sum) << 4);
      sres_q <= '0;
      sbit_q <= 62'(1) << 60;
    end else if (sbusy_q) begin
      if (sx_q >= sq_trial) begin
        sx_q   <= sx_q - sq_trial;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // Restoring divider, one quotient bit a step, shared by row count and hold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (ctl_i.rows_start || ctl_i.div_hold_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= 5'd31;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 5'd1;
      if (dcnt_q == 5'd0) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rows_start) begin
      dq_q   <= 32'($unsigned(bh)) + 32'(rs_q) - 32'd1;
      dden_q <= rs_q;
      drem_q <= '0;
    end else if (ctl_i.div_hold_start) begin
      dq_q   <= 32'(sres_q[30:0]) + 32'(spd_f);
      dden_q <= {2'b00, spd_f, 1'b0};
      drem_q <= '0;
    end else if (dbusy_q) begin
      if (dtrial >= {1'b0, dden_q}) begin
        drem_q <= 17'(dtrial - {1'b0, dden_q});
        dq_q   <= {dq_q[30:0], 1'b1};
      end else begin
        drem_q <= dtrial[16:0];
        dq_q   <= {dq_q[30:0], 1'b0};
      end
    end
  end

  // Output register: hold the item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      olast_q <= ctl_i.out_last;
      unique case (ctl_i.osel)
        OSEL_HOME_CH: begin
          osv_q <= 1'b1; on_q <= '0; oe_q <= '0;
          od_q <= -$signed({1'b0, ch_q}); ocmd_q <= CMD_NONE;
        end
        OSEL_HOME_LAND: begin
          osv_q <= 1'b1; on_q <= '0; oe_q <= '0;
          od_q <= -$signed({1'b0, land_q}); ocmd_q <= CMD_NONE;
        end
        OSEL_WAYPT: begin
          osv_q <= 1'b1; on_q <= n_sat; oe_q <= e_sat;
          od_q <= -$signed({1'b0, ch_q}); ocmd_q <= CMD_NONE;
        end
        default: begin
          osv_q <= 1'b0; on_q <= '0; oe_q <= '0;
          od_q <= '0; ocmd_q <= ctl_i.out_cmd;
        end
      endcase
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.setpoint_valid = osv_q;
  assign out_o.north          = on_q;
  assign out_o.east           = oe_q;
  assign out_o.down           = od_q;
  assign out_o.command        = ocmd_q;
  assign out_o.last           = olast_q;

endmodule

// File: rtl/core/cms_checker.sv
module cms_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic                                setpoint_valid_i,
  input logic signed [cms_pkg::NE_W-1:0]     north_i,
  input logic signed [cms_pkg::NE_W-1:0]     east_i,
  input logic signed [cms_pkg::DOWN_W-1:0]   down_i,
  input logic [cms_pkg::CMD_W-1:0]           command_i
);
  import cms_pkg::*;

  // Pending item stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // Command items carry no position
  a_cmd_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && command_i != CMD_NONE |->
      !setpoint_valid_i && north_i == '0 && east_i == '0 && down_i == '0)
    else $error("command item carries a setpoint");

  // Setpoint items carry no command
  a_sp_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && setpoint_valid_i |-> command_i == CMD_NONE)
    else $error("setpoint item carries a command");

  // Setpoints are never below ground
  a_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && setpoint_valid_i |-> down_i <= 0)
    else $error("setpoint down is positive");

endmodule

bind coverage_mission_sequencer_unit cms_checker u_cms_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .setpoint_valid_i (out_o.setpoint_valid),
  .north_i          (out_o.north),
  .east_i           (out_o.east),
  .down_i           (out_o.down),
  .command_i        (out_o.command)
);

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cms_pkg::*;

  localparam int SETTLE = 150;

  typedef struct packed {
    logic                     spv;
    logic signed [NE_W-1:0]   north;
    logic signed [NE_W-1:0]   east;
    logic signed [DOWN_W-1:0] down;
    logic [CMD_W-1:0]         command;
    logic                     last;
  } setpoint_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cms_in_if  in_if ();
  cms_out_if out_if ();
  cms_cfg_if cfg_if ();

  coverage_mission_sequencer_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Register copy
  logic [16:0]        row_pitch, cruise_alt;
  logic signed [23:0] org_x, org_y, home_x, home_y;
  logic [13:0]        speed;
  logic [7:0]         warm_ticks;

  // Mission state copy
  logic [2:0]  phase;
  logic [7:0]  warm_cnt;
  int unsigned phase_cnt, hold_left, route_idx, rows;
  longint      box_min_x, box_max_x, box_min_y, box_max_y, land_alt;
  bit          any_vertex, land_cmd_done, disarm_sent;

  setpoint_t   setpoint_q[$];
  setpoint_t   got, want;
  int          errors, n_ticks, n_vertices, n_results, n_advances, n_writes;
  bit          gappy = 1'b1;
  int          sink_stall, sink_hold_off;

  function automatic longint sat_ne(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< POS_WIDTH) - 1;
    lo = -(longint'(1) <<< POS_WIDTH);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Ticks to fly a leg: distance over speed, halves rounded up
  function automatic int unsigned leg_ticks(longint dx, longint dy);
    longint unsigned ax, ay, v, m, n;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    v = speed < 10 ? 10 : speed;
    m = int_sqrt(400 * (ax * ax + ay * ay));
    n = (m + v) / (2 * v);
    if (n < MIN_HOLD_TICKS) n = MIN_HOLD_TICKS;
    if (n > 64'hFFFFFF) n = 64'hFFFFFF;
    return int'(n);
  endfunction

  function automatic void waypoint(int unsigned k, output longint gx, output longint gy);
    int unsigned r;
    longint y;
    r = k >> 1;
    y = box_min_y + longint'(r) * longint'(row_pitch);
    if (y > box_max_y) y = box_max_y;
    gx = longint'(org_x) + (((k ^ r) & 1) ? box_max_x : box_min_x);
    gy = longint'(org_y) - y;
  endfunction

  function automatic int unsigned row_total();
    longint w, h, n;
    if (!any_vertex) return 0;
    w = box_max_x - box_min_x;
    h = box_max_y - box_min_y;
    if (w <= 0 || h <= 0) return 0;
    if (row_pitch == 0) return MAX_ROWS;
    n = (h + row_pitch - 1) / row_pitch;
    if (n < 1) n = 1;
    if (n > MAX_ROWS) n = MAX_ROWS;
    return int'(n);
  endfunction

  function automatic setpoint_t mk(logic spv, longint n, longint e, longint d,
                                   logic [CMD_W-1:0] c);
    setpoint_t s;
    s.spv = spv;
    s.north = n[NE_W-1:0];
    s.east = e[NE_W-1:0];
    s.down = d[DOWN_W-1:0];
    s.command = c;
    s.last = 1'b0;
    return s;
  endfunction

  // Advance the mission by one tick and queue what it emits
  function automatic void predict_tick();
    setpoint_t r[$];
    int unsigned npts, nx;
    longint cx, cy, px, py;
    if (warm_cnt < warm_ticks) begin
      r.insert(r.size(), mk(1'b1, 0, 0, -longint'(cruise_alt), CMD_NONE));
      warm_cnt++;
      if (warm_cnt == warm_ticks) begin
        r.insert(r.size(), mk(1'b0, 0, 0, 0, CMD_MODE));
        r.insert(r.size(), mk(1'b0, 0, 0, 0, CMD_ARM));
      end
    end else begin
      case (phase)
        PH_WARMUP: phase = PH_TAKEOFF;
        PH_TAKEOFF, PH_RETURN: begin
          r.insert(r.size(), mk(1'b1, 0, 0, -longint'(cruise_alt), CMD_NONE));
          phase_cnt++;
          if (phase_cnt >= PHASE_HOLD_TICKS) begin
            phase_cnt = 0;
            if (phase == PH_TAKEOFF) begin
              phase = PH_CRUISE;
              route_idx = 0;
              hold_left = 0;
              rows = row_total();
            end else begin
              phase = PH_LAND;
              land_alt = cruise_alt;
            end
          end
        end
        PH_CRUISE: begin
          if (rows == 0) begin
            phase = PH_RETURN;
          end else begin
            npts = 2 * (rows + 1);
            if (route_idx >= npts) route_idx = 0;
            waypoint(route_idx, cx, cy);
            r.insert(r.size(), mk(1'b1, sat_ne(cy - longint'(home_y)),
                                  sat_ne(cx - longint'(home_x)),
                                  -longint'(cruise_alt), CMD_NONE));
            if (hold_left > 0) begin
              hold_left--;
            end else begin
              nx = route_idx + 1;
              if (nx >= npts) nx = 0;
              waypoint(nx, px, py);
              hold_left = leg_ticks(px - cx, py - cy);
              route_idx = nx;
              n_advances++;
            end
          end
        end
        PH_LAND: begin
          land_alt -= 10;
          if (land_alt < 20) land_alt = 20;
          r.insert(r.size(), mk(1'b1, 0, 0, -land_alt, CMD_NONE));
          if (!land_cmd_done) begin
            r.insert(r.size(), mk(1'b0, 0, 0, 0, CMD_LAND));
            land_cmd_done = 1;
          end
          if (land_alt <= 25) phase = PH_LANDED;
        end
        default: begin
          if (!disarm_sent) begin
            r.insert(r.size(), mk(1'b0, 0, 0, 0, CMD_DISARM));
            disarm_sent = 1;
          end
        end
      endcase
    end
    if (r.size() > 0) r[r.size()-1].last = 1'b1;
    setpoint_q = {setpoint_q, r};
  endfunction

  function automatic void predict_vertex(logic signed [23:0] vx, logic signed [23:0] vy);
    if (phase != PH_WARMUP || warm_cnt != 0) return;
    if (!any_vertex) begin
      box_min_x = vx; box_max_x = vx;
      box_min_y = vy; box_max_y = vy;
      any_vertex = 1;
    end else begin
      if (vx < box_min_x) box_min_x = vx;
      if (vx > box_max_x) box_max_x = vx;
      if (vy < box_min_y) box_min_y = vy;
      if (vy > box_max_y) box_max_y = vy;
    end
  endfunction

  // Offer one item, hold it until taken, then drop valid
  task automatic send_item(logic is_tick, logic signed [23:0] vx, logic signed [23:0] vy);
    int gap;
    gap = gappy ? $urandom_range(0, 12) : 0;
    repeat (gap) @(negedge clk_i);
    in_if.cmd = is_tick;
    in_if.vertex_x = vx;
    in_if.vertex_y = vy;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    if (is_tick) begin
      predict_tick();
      n_ticks++;
    end else begin
      predict_vertex(vx, vy);
      n_vertices++;
    end
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic tick();
    send_item(1'b1, 24'($urandom), 24'($urandom));
  endtask

  task automatic drain();
    while (setpoint_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
    cfg_if.index = idx;
    cfg_if.data = value[CFG_DATA_W-1:0];
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_ROW_SPACING:   row_pitch = value[16:0];
      REG_CRUISE_HEIGHT: cruise_alt = value[16:0];
      REG_ORIGIN_X:      org_x = value[23:0];
      REG_ORIGIN_Y:      org_y = value[23:0];
      REG_HOME_X:        home_x = value[23:0];
      REG_HOME_Y:        home_y = value[23:0];
      REG_CRUISE_SPEED:  speed = value[13:0];
      REG_WARMUP_TICKS:  warm_ticks = value[7:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Result side: stall per item, plus any long hold-off asked for
  always @(negedge clk_i) begin
    if (sink_hold_off > 0) begin
      out_if.ready = 1'b0;
      sink_hold_off--;
    end else if (sink_stall > 0) begin
      out_if.ready = 1'b0;
      sink_stall--;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // Compare each item against the oldest expected setpoint
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.setpoint_valid, out_if.north, out_if.east, out_if.down,
              out_if.command, out_if.last};
      n_results++;
      sink_stall = gappy ? $urandom_range(0, 12) : 0;
      if (setpoint_q.size() == 0) begin
        $error("unexpected item: north %0d east %0d command %0d",
               got.north, got.east, got.command);
        errors++;
      end else begin
        want = setpoint_q.pop_front();
        if (got.spv !== want.spv) begin
          $error("setpoint_valid: expected %0d, got %0d", want.spv, got.spv);
          errors++;
        end
        if (got.north !== want.north) begin
          $error("north: expected %0d, got %0d", want.north, got.north);
          errors++;
        end
        if (got.east !== want.east) begin
          $error("east: expected %0d, got %0d", want.east, got.east);
          errors++;
        end
        if (got.down !== want.down) begin
          $error("down: expected %0d, got %0d", want.down, got.down);
          errors++;
        end
        if (got.command !== want.command) begin
          $error("command: expected %0d, got %0d", want.command, got.command);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Registers at mission start: narrow altitude, fast cruise, short warmup
  task automatic test_setup();
    write_reg(REG_ROW_SPACING, 500);
    write_reg(REG_CRUISE_HEIGHT, 30);
    write_reg(REG_CRUISE_SPEED, 10000);
    write_reg(REG_WARMUP_TICKS, 3);
  endtask

  // Build the map box from a handful of vertices
  task automatic test_map_load();
    send_item(1'b0, -24'sd1500, -24'sd1000);
    send_item(1'b0, 24'sd1500, 24'sd1200);
    send_item(1'b0, 24'sd200, -24'sd300);
    send_item(1'b0, -24'sd700, 24'sd2600);
    send_item(1'b0, 24'sd900, 24'sd100);
  endtask

  // Warmup setpoints, then mode and arm on the last one
  task automatic test_warmup();
    repeat (3) tick();
  endtask

  // Vertices after the first tick must be dropped, whatever their value
  task automatic test_late_vertices();
    send_item(1'b0, 24'sh800000, 24'sh7FFFFF);
    send_item(1'b0, 24'sh7FFFFF, 24'sh800000);
    send_item(1'b0, 24'sd0, -24'sd1);
    send_item(1'b0, -24'sd1, 24'sd0);
  endtask

  // Phase change tick and the takeoff hold into cruise
  task automatic test_takeoff();
    repeat (27) tick();
  endtask

  task automatic cruise_burst(int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 15) send_item(1'b0, 24'($urandom), 24'($urandom));
      tick();
    end
  endtask

  // Cruise under several register settings, extremes included
  task automatic test_cruise_random();
    cruise_burst(20);
    drain();
    write_reg(REG_ROW_SPACING, 1);
    write_reg(REG_ORIGIN_X, -8388608);
    write_reg(REG_ORIGIN_Y, -8388608);
    write_reg(REG_HOME_X, 8388607);
    write_reg(REG_HOME_Y, 8388607);
    cruise_burst(15);
    drain();
    write_reg(REG_ROW_SPACING, 100000);
    write_reg(REG_CRUISE_HEIGHT, 100000);
    write_reg(REG_ORIGIN_X, 8388607);
    write_reg(REG_ORIGIN_Y, 8388607);
    write_reg(REG_HOME_X, -8388608);
    write_reg(REG_HOME_Y, -8388608);
    cruise_burst(15);
    drain();
    write_reg(REG_ROW_SPACING, 300);
    write_reg(REG_CRUISE_HEIGHT, 1000);
    write_reg(REG_ORIGIN_X, 4000);
    write_reg(REG_ORIGIN_Y, -3500);
    write_reg(REG_HOME_X, 4000);
    write_reg(REG_HOME_Y, -4000);
    gappy = 1'b0;
    cruise_burst(15);
    gappy = 1'b1;
  endtask

  // Hold the result side off while ticks keep coming, then pause to drain
  task automatic test_backpressure();
    sink_hold_off = 400;
    gappy = 1'b0;
    repeat (20) tick();
    gappy = 1'b1;
    drain();
  endtask

  // Slowest speed last: holds grow long but setpoints still flow
  task automatic test_slow_cruise();
    write_reg(REG_CRUISE_SPEED, 10);
    cruise_burst(25);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = 1'b0;
    in_if.vertex_x = '0;
    in_if.vertex_y = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    row_pitch = 300; cruise_alt = 1000;
    org_x = 4000; org_y = -3500; home_x = 4000; home_y = -4000;
    speed = 200; warm_ticks = 12;
    phase = PH_WARMUP; warm_cnt = 0; phase_cnt = 0; hold_left = 0;
    route_idx = 0; rows = 0; any_vertex = 0; land_cmd_done = 0; disarm_sent = 0;
    box_min_x = 0; box_max_x = 0; box_min_y = 0; box_max_y = 0;
    land_alt = 1000;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_setup();
    test_map_load();
    test_warmup();
    test_late_vertices();
    test_takeoff();
    test_cruise_random();
    test_backpressure();
    test_slow_cruise();

    drain();
    $display("Ran %0d ticks and %0d vertex items over %0d register writes;", n_ticks,
             n_vertices, n_writes);
    $display("checked %0d result items across %0d waypoint advances.", n_results,
             n_advances);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/cms_pkg.sv
rtl/core/cms_ifs.sv
rtl/core/cms_ctrl.sv
rtl/core/cms_dp.sv
rtl/core/coverage_mission_sequencer_unit.sv
rtl/core/cms_checker.sv
test/tb.sv
